// ===== src/ahsl_pkg.sv =====
package ahsl_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int ERR_LEN = 34;
  localparam int EXIT_LEN = 12;
  localparam int IDX_W = $clog2(ERR_LEN + 1);
  localparam logic [31:0] ADDR_STEP = 32'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_OK = "k";
  localparam logic [7:0] CH_CMD_ADDR = "a";
  localparam logic [7:0] CH_CMD_WMSB = "w";
  localparam logic [7:0] CH_CMD_WLSB = "W";
  localparam logic [7:0] CH_CMD_CSUM = "c";
  localparam logic [7:0] CH_CMD_JUMP = "j";
  localparam logic [7:0] CH_CMD_PADDR = "p";
  localparam logic [7:0] CH_CMD_QUIT = "q";

  localparam logic [EXIT_LEN*8-1:0] EXIT_TEXT = {CH_LF, CH_CR, "wload exit"};
  localparam logic [ERR_LEN*8-1:0] ERR_TEXT =
    {CH_LF, CH_CR, "wload error: unknown directive: "};

  typedef enum logic [1:0] {
    KIND_TX  = 2'd0,
    KIND_WR  = 2'd1,
    KIND_JMP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ADDR = 2'd1,
    CMD_WMSB = 2'd2,
    CMD_WLSB = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_OK    = 3'd0,
    OP_WRITE = 3'd1,
    OP_JUMP  = 3'd2,
    OP_CSUM  = 3'd3,
    OP_PADDR = 3'd4,
    OP_EXIT  = 3'd5,
    OP_ERR   = 3'd6
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [31:0] address;
    logic [31:0] data;
  } job_t;

endpackage

// ===== src/ahsl_if.sv =====
interface ahsl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_char;

  modport source (output valid, func, rx_char, input ready);
  modport sink (input valid, func, rx_char, output ready);
endinterface

interface ahsl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_char;
  logic [31:0] address;
  logic [31:0] data;
  logic        last;

  modport source (output valid, kind, tx_char, address, data, last, input ready);
  modport sink (input valid, kind, tx_char, address, data, last, output ready);
endinterface

// ===== src/ahsl_front.sv =====
module ahsl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ahsl_in_if.sink       in_ch,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ahsl_pkg::job_t q_job_o
);
  import ahsl_pkg::*;

  logic [31:0] load_addr_q, load_addr_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  cmd_e        cmd_q, cmd_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [3:0]  hex_val;
  logic [4:0]  shift;
  logic [31:0] acc_new;
  logic [7:0]  sum_new;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {["0":"9"]}) begin
      v = c - "0";
    end else if (c inside {["a":"f"]}) begin
      v = c - "a" + 8'd10;
    end else if (c inside {["A":"F"]}) begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  assign in_ch.ready = !q_full_i;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    hex_val = hex_value(in_ch.rx_char);
    if (cmd_q == CMD_WLSB) begin
      shift = {cnt_q[2:1], ~cnt_q[0], 2'b00};
    end else begin
      shift = {~cnt_q, 2'b00};
    end
    acc_new = acc_q | (32'(hex_val) << shift);
    sum_new = sum_q + acc_new[31:24] + acc_new[23:16] + acc_new[15:8] + acc_new[7:0];
  end

  always_comb begin
    load_addr_d = load_addr_q;
    sum_d = sum_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    cmd_d = cmd_q;
    halted_d = halted_q;
    q_push_o = 1'b0;
    q_job_o = '{op: OP_OK, address: '0, data: '0};
    if (accept) begin
      if (in_ch.func) begin
        load_addr_d = '0;
        sum_d = '0;
        acc_d = '0;
        cnt_d = '0;
        cmd_d = CMD_NONE;
        halted_d = 1'b0;
        q_push_o = 1'b1;
      end else if (!halted_q) begin
        if (cmd_q != CMD_NONE) begin
          if (in_ch.rx_char != CH_SPACE) begin
            if (cnt_q == 3'd7) begin
              sum_d = sum_new;
              if (cmd_q == CMD_ADDR) begin
                load_addr_d = acc_new;
              end else begin
                q_push_o = 1'b1;
                q_job_o = '{op: OP_WRITE, address: load_addr_q, data: acc_new};
                load_addr_d = load_addr_q + ADDR_STEP;
              end
              cmd_d = CMD_NONE;
              cnt_d = '0;
              acc_d = '0;
            end else begin
              cnt_d = cnt_q + 3'd1;
              acc_d = acc_new;
            end
          end
        end else begin
          case (in_ch.rx_char)
            CH_CMD_ADDR: begin
              cmd_d = CMD_ADDR;
              cnt_d = '0;
              acc_d = '0;
            end
            CH_CMD_WMSB: begin
              cmd_d = CMD_WMSB;
              cnt_d = '0;
              acc_d = '0;
            end
            CH_CMD_WLSB: begin
              cmd_d = CMD_WLSB;
              cnt_d = '0;
              acc_d = '0;
            end
            CH_CMD_CSUM: begin
              q_push_o = 1'b1;
              q_job_o = '{op: OP_CSUM, address: '0, data: {24'h0, sum_q}};
            end
            CH_CMD_JUMP: begin
              q_push_o = 1'b1;
              q_job_o = '{op: OP_JUMP, address: load_addr_q, data: '0};
            end
            CH_CMD_PADDR: begin
              q_push_o = 1'b1;
              q_job_o = '{op: OP_PADDR, address: load_addr_q, data: '0};
            end
            CH_CMD_QUIT: begin
              q_push_o = 1'b1;
              q_job_o = '{op: OP_EXIT, address: '0, data: '0};
              halted_d = 1'b1;
            end
            CH_SPACE, CH_LF, CH_CR: begin
            end
            default: begin
              q_push_o = 1'b1;
              q_job_o = '{op: OP_ERR, address: '0, data: {24'h0, in_ch.rx_char}};
              halted_d = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= '0;
      sum_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      cmd_q <= CMD_NONE;
      halted_q <= 1'b1;
    end else begin
      load_addr_q <= load_addr_d;
      sum_q <= sum_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      cmd_q <= cmd_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== src/ahsl_queue.sv =====
module ahsl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ahsl_pkg::job_t push_job_i,
  input  logic           pop_i,
  output ahsl_pkg::job_t pop_job_o,
  output logic           full_o,
  output logic           empty_o
);
  import ahsl_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/ahsl_back.sv =====
module ahsl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ahsl_pkg::job_t q_job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  ahsl_out_if.source     out_ch
);
  import ahsl_pkg::*;

  job_t             cur_q;
  logic [IDX_W-1:0] idx_q;
  logic             active_q;
  logic             out_valid_q;
  kind_e            kind_q, kind_n;
  logic [7:0]       tx_q, tx_n;
  logic [31:0]      addr_q, addr_n;
  logic [31:0]      data_q, data_n;
  logic             last_q, last_n;

  logic             advance;
  logic [2:0]       nib_sel;
  logic [3:0]       nibble;
  logic [3:0]       exit_sel;
  logic [IDX_W-1:0] err_sel;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'("0") + 8'(v) : 8'("a") + 8'(v) - 8'd10;
  endfunction

  assign advance = active_q && (!out_valid_q || out_ch.ready);
  assign q_pop_o = !q_empty_i && (!active_q || (advance && last_n));

  always_comb begin
    nib_sel = 3'd7 - idx_q[2:0];
    exit_sel = 4'(EXIT_LEN - 1) - idx_q[3:0];
    err_sel = IDX_W'(ERR_LEN - 1) - idx_q;
    nibble = 4'h0;
    kind_n = KIND_TX;
    tx_n = 8'h00;
    addr_n = '0;
    data_n = '0;
    last_n = 1'b1;
    case (cur_q.op)
      OP_OK: begin
        tx_n = CH_OK;
      end
      OP_WRITE: begin
        kind_n = KIND_WR;
        addr_n = cur_q.address;
        data_n = cur_q.data;
      end
      OP_JUMP: begin
        kind_n = KIND_JMP;
        addr_n = cur_q.address;
      end
      OP_CSUM: begin
        nibble = idx_q[0] ? cur_q.data[3:0] : cur_q.data[7:4];
        tx_n = hex_char(nibble);
        last_n = idx_q[0];
      end
      OP_PADDR: begin
        nibble = cur_q.address[{nib_sel, 2'b00} +: 4];
        tx_n = hex_char(nibble);
        last_n = (idx_q[2:0] == 3'd7);
      end
      OP_EXIT: begin
        tx_n = EXIT_TEXT[{exit_sel, 3'b000} +: 8];
        last_n = (idx_q == IDX_W'(EXIT_LEN - 1));
      end
      OP_ERR: begin
        if (idx_q == IDX_W'(ERR_LEN)) begin
          tx_n = cur_q.data[7:0];
        end else begin
          tx_n = ERR_TEXT[{err_sel, 3'b000} +: 8];
        end
        last_n = (idx_q == IDX_W'(ERR_LEN));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        active_q <= 1'b1;
        idx_q <= '0;
      end else if (advance && last_n) begin
        active_q <= 1'b0;
      end else if (advance) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end
    if (advance) begin
      kind_q <= kind_n;
      tx_q <= tx_n;
      addr_q <= addr_n;
      data_q <= data_n;
      last_q <= last_n;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.kind = kind_q;
  assign out_ch.tx_char = tx_q;
  assign out_ch.address = addr_q;
  assign out_ch.data = data_q;
  assign out_ch.last = last_q;

endmodule

// ===== src/ascii_hex_serial_loader.sv =====
// Serial loader command parser. An input item is taken whenever the four-entry
// command queue has room; the front end updates the address, checksum
// and digit state at once and queues one job per item that answers. The back end
// turns each job into its result items at one item per cycle while the output
// side is ready: one item for a start, write or jump, two for a checksum, eight
// for an address report, twelve for the exit text and thirty-five for an error.
// A stalled output fills the queue, and input ready drops only when it is full.
module ascii_hex_serial_loader (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahsl_in_if.sink    in_i,
  ahsl_out_if.source out_o
);
  import ahsl_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  ahsl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job)
  );

  ahsl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  ahsl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_job_i   (pop_job),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_ch    (out_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("Job queued while the queue is full.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Job taken from an empty queue.");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind != KIND_TX)) |-> out_o.last)
    else $error("Write or jump item is not the last item of its input.");

  a_queue_empty_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_empty && !q_pop) |=> !q_empty)
    else $error("Queued job was lost.");

endmodule

// ===== dv/ahsl_reply_checker.sv =====
`timescale 1ns / 100ps

module ahsl_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_func_i,
  input  logic [7:0]  in_rx_char_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [7:0]  out_tx_char_i,
  input  logic [31:0] out_address_i,
  input  logic [31:0] out_data_i,
  input  logic        out_last_i,
  output int          mismatch_cnt_o,
  output int          outstanding_o
);
  import ahsl_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_char;
    logic [31:0] address;
    logic [31:0] data;
    logic        last;
  } reply_t;

  reply_t      reply_q[$];
  logic [31:0] load_addr;
  logic [7:0]  byte_sum;
  logic [31:0] word_acc;
  logic [2:0]  digit_cnt;
  cmd_e        pend_cmd;
  logic        halted;
  int          mismatches;
  int          outstanding;

  assign mismatch_cnt_o = mismatches;
  assign outstanding_o  = outstanding;

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? "0" + 8'(v) : "a" + 8'(v) - 8'd10;
  endfunction

  function automatic void push_reply(kind_e k, logic [7:0] ch, logic [31:0] addr,
                                     logic [31:0] word);
    reply_t r;
    r.kind    = k;
    r.tx_char = ch;
    r.address = addr;
    r.data    = word;
    r.last    = 1'b0;
    reply_q.push_back(r);
  endfunction

  // Message texts open with a line feed and a carriage return.
  function automatic void push_text(string s);
    push_reply(KIND_TX, CH_LF, 32'd0, 32'd0);
    push_reply(KIND_TX, CH_CR, 32'd0, 32'd0);
    for (int j = 0; j < s.len(); j++) begin
      push_reply(KIND_TX, s[j], 32'd0, 32'd0);
    end
  endfunction

  task automatic predict_replies(input logic f, input logic [7:0] c);
    int          first;
    int          sh;
    int          i;
    logic [2:0]  d;
    logic [31:0] w;
    first = reply_q.size();
    if (f) begin
      byte_sum  = 8'd0;
      load_addr = 32'd0;
      word_acc  = 32'd0;
      digit_cnt = 3'd0;
      pend_cmd  = CMD_NONE;
      halted    = 1'b0;
      push_reply(KIND_TX, CH_OK, 32'd0, 32'd0);
    end else if (!halted) begin
      if (pend_cmd != CMD_NONE) begin
        if (c != CH_SPACE) begin
          d = digit_cnt;
          if (pend_cmd == CMD_WLSB) begin
            sh = int'(d[2:1]) * 8 + (d[0] ? 0 : 4);
          end else begin
            sh = (7 - int'(d)) * 4;
          end
          word_acc |= 32'(hex_nibble(c)) << sh;
          if (d == 3'd7) begin
            w = word_acc;
            byte_sum += w[31:24] + w[23:16] + w[15:8] + w[7:0];
            if (pend_cmd == CMD_ADDR) begin
              load_addr = w;
            end else begin
              push_reply(KIND_WR, 8'd0, load_addr, w);
              load_addr += 32'd4;
            end
            pend_cmd  = CMD_NONE;
            digit_cnt = 3'd0;
            word_acc  = 32'd0;
          end else begin
            digit_cnt = d + 3'd1;
          end
        end
      end else begin
        case (c)
          CH_CMD_ADDR: pend_cmd = CMD_ADDR;
          CH_CMD_WMSB: pend_cmd = CMD_WMSB;
          CH_CMD_WLSB: pend_cmd = CMD_WLSB;
          CH_CMD_CSUM: begin
            push_reply(KIND_TX, hex_digit(byte_sum[7:4]), 32'd0, 32'd0);
            push_reply(KIND_TX, hex_digit(byte_sum[3:0]), 32'd0, 32'd0);
          end
          CH_CMD_JUMP: push_reply(KIND_JMP, 8'd0, load_addr, 32'd0);
          CH_CMD_PADDR: begin
            for (i = 7; i >= 0; i--) begin
              push_reply(KIND_TX, hex_digit(load_addr[4*i +: 4]), 32'd0, 32'd0);
            end
          end
          CH_CMD_QUIT: begin
            push_text("wload exit");
            halted = 1'b1;
          end
          CH_SPACE, CH_LF, CH_CR: ;
          default: begin
            push_text("wload error: unknown directive: ");
            push_reply(KIND_TX, c, 32'd0, 32'd0);
            halted = 1'b1;
          end
        endcase
        if (pend_cmd != CMD_NONE) begin
          digit_cnt = 3'd0;
          word_acc  = 32'd0;
        end
      end
    end
    if (reply_q.size() > first) reply_q[reply_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp_r;
    if (!rst_ni) begin
      load_addr  = 32'd0;
      byte_sum   = 8'd0;
      word_acc   = 32'd0;
      digit_cnt  = 3'd0;
      pend_cmd   = CMD_NONE;
      halted     = 1'b1;
      mismatches = 0;
      reply_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_replies(in_func_i, in_rx_char_i);
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $error("unexpected item: kind %0d tx_char %h address %h data %h last %0d",
                 out_kind_i, out_tx_char_i, out_address_i, out_data_i, out_last_i);
          mismatches++;
        end else begin
          exp_r = reply_q.pop_front();
          if (out_kind_i !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, out_kind_i);
            mismatches++;
          end
          if (out_tx_char_i !== exp_r.tx_char) begin
            $error("tx_char: expected %h, got %h", exp_r.tx_char, out_tx_char_i);
            mismatches++;
          end
          if (out_address_i !== exp_r.address) begin
            $error("address: expected %h, got %h", exp_r.address, out_address_i);
            mismatches++;
          end
          if (out_data_i !== exp_r.data) begin
            $error("data: expected %h, got %h", exp_r.data, out_data_i);
            mismatches++;
          end
          if (out_last_i !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_last_i);
            mismatches++;
          end
        end
      end
    end
    outstanding = reply_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ahsl_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int RUN_LIMIT    = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_cnt;
  int   outstanding;
  int   burst_left = 0;
  int   items_sent = 0;
  int   random_base;
  logic gen_halted = 1'b1;

  ahsl_in_if  in_if ();
  ahsl_out_if out_if ();

  ascii_hex_serial_loader u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ahsl_reply_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_ready_i     (in_if.ready),
    .in_func_i      (in_if.func),
    .in_rx_char_i   (in_if.rx_char),
    .out_valid_i    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .out_kind_i     (out_if.kind),
    .out_tx_char_i  (out_if.tx_char),
    .out_address_i  (out_if.address),
    .out_data_i     (out_if.data),
    .out_last_i     (out_if.last),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The sender offers items in bursts; ignored items while halted are not counted.
  task automatic send_item(input logic f, input logic [7:0] c);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.rx_char <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    if (f || !gen_halted) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int j = 0; j < s.len(); j++) send_item(1'b0, s[j]);
  endtask

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(0, 2))
      0:       return "0" + 8'($urandom_range(0, 9));
      1:       return "a" + 8'($urandom_range(0, 5));
      default: return "A" + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return rand_hex_char();
    if (r < 93) return 8'($urandom);
    return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] rand_unknown_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c inside {CH_CMD_ADDR, CH_CMD_WMSB, CH_CMD_WLSB, CH_CMD_CSUM,
                         CH_CMD_JUMP, CH_CMD_PADDR, CH_CMD_QUIT, CH_SPACE, CH_LF,
                         CH_CR});
    return c;
  endfunction

  task automatic send_word(input logic [7:0] cmd);
    int mode;
    send_item(1'b0, cmd);
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b0, CH_SPACE);
      if (mode == 0) begin
        send_item(1'b0, ($urandom_range(0, 1) == 0) ? "f" : "F");
      end else if (mode == 1) begin
        send_item(1'b0, "0");
      end else begin
        send_item(1'b0, rand_digit_char());
      end
    end
  endtask

  task automatic run_session();
    int n_cmds;
    int r;
    send_item(1'b1, 8'($urandom));
    gen_halted = 1'b0;
    n_cmds = $urandom_range(2, 14);
    for (int k = 0; k < n_cmds; k++) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        send_word(CH_CMD_ADDR);
      end else if (r < 38) begin
        send_word(CH_CMD_WMSB);
      end else if (r < 60) begin
        send_word(CH_CMD_WLSB);
      end else if (r < 68) begin
        send_item(1'b0, CH_CMD_CSUM);
      end else if (r < 74) begin
        send_item(1'b0, CH_CMD_JUMP);
      end else if (r < 82) begin
        send_item(1'b0, CH_CMD_PADDR);
      end else if (r < 92) begin
        send_item(1'b0, rand_blank());
      end else if (r < 95) begin
        // A partly read word is dropped by the next session start.
        send_item(1'b0, ($urandom_range(0, 1) == 0) ? CH_CMD_WMSB : CH_CMD_WLSB);
        repeat ($urandom_range(1, 7)) send_item(1'b0, rand_hex_char());
        return;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(1'b0, CH_CMD_QUIT);
      gen_halted = 1'b1;
    end else if (r < 75) begin
      send_item(1'b0, rand_unknown_char());
      gen_halted = 1'b1;
    end
    if (gen_halted && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.func    <= 1'b0;
    in_if.rx_char <= 8'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(1'b0, "x");
    send_item(1'b1, 8'd0);
    gen_halted = 1'b0;
    send_item(1'b0, CH_CMD_ADDR);
    send_text("FFFF ffff");
    send_item(1'b0, CH_CMD_WLSB);
    send_text("89");
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_LF);
    send_text("gAbc");
    send_item(1'b0, CH_CMD_WMSB);
    send_text("0123cdef");
    send_item(1'b0, CH_CMD_PADDR);
    send_item(1'b0, CH_CMD_CSUM);
    send_item(1'b0, CH_CMD_JUMP);
    send_item(1'b0, CH_SPACE);
    send_item(1'b0, CH_LF);
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_CMD_QUIT);
    gen_halted = 1'b1;
    send_item(1'b0, CH_CMD_PADDR);
    send_item(1'b1, 8'hff);
    gen_halted = 1'b0;
    send_item(1'b0, 8'hff);
    gen_halted = 1'b1;

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) run_session();
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS ascii_hex_serial_loader");
    end else begin
      $display("FAIL ascii_hex_serial_loader");
    end
    $finish;
  end

  // The receiver stalls on a pattern of its own, with two long hold-offs.
  initial begin
    int rx_cycle;
    int hold_left;
    int seg_left;
    int stall_pct;
    rx_cycle  = 0;
    hold_left = 0;
    seg_left  = 0;
    stall_pct = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_cycle == 300 || rx_cycle == 1200) begin
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < RUN_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("FAIL ascii_hex_serial_loader");
    $finish;
  end

endmodule
